// ===== rtl/lztd_pkg.sv =====
package lztd_pkg;

	// Default sizes of the history window and of one match chunk.
	localparam int HISTORY_BITS_DEF = 16;
	localparam int MAX_RUN_DEF      = 64;

	// Field widths fixed by the token format.
	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int DIST_W  = 16;

	// Token kinds.
	localparam logic [OP_W-1:0] OP_LITERAL = 2'd0;
	localparam logic [OP_W-1:0] OP_MATCH   = 2'd1;
	localparam logic [OP_W-1:0] OP_END     = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] literal;
		logic [LEN_W-1:0]  match_length;
		logic [DIST_W-1:0] match_distance;
	} token_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic              end_of_stream;
		logic              bad_distance;
	} result_t;

	// One result offered by the sequencer to the output register.
	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

endpackage

// ===== rtl/lz77_token_decoder.sv =====
// Channel  Direction  Payload            Handshake
// in       to block   lztd_pkg::token_t  in_valid / in_ready
// out      from block lztd_pkg::result_t out_valid / out_ready
//
// A literal or end token holds the sequencer for an intake step, then an
// emit step. A match chunk takes an intake step and then, per copied byte,
// a history read, then an emit and write back, because the registered read
// of the next byte must see the byte written just before it. A chunk with a
// bad distance skips the reads and emits one byte per cycle when not stalled.
// Reset clears the write position and produced count; history is unset.
// The output register holds one result, so a stalled consumer pauses the
// sequencer; a new token is taken only while the sequencer is idle.
module lz77_token_decoder #(
	parameter int HISTORY_BITS = lztd_pkg::HISTORY_BITS_DEF,
	parameter int MAX_RUN      = lztd_pkg::MAX_RUN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lztd_pkg::token_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lztd_pkg::result_t out_data
);

	import lztd_pkg::*;

	emit_t   emit;
	logic    out_free;
	logic    out_valid_q;
	result_t out_q;

	lztd_seq #(
		.HISTORY_BITS (HISTORY_BITS),
		.MAX_RUN      (MAX_RUN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.emit     (emit),
		.out_free (out_free)
	);

	// Output register: loads when empty or when its result transfers.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && out_free) begin
			out_q <= emit.res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/lztd_ram.sv =====
module lztd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lztd_seq.sv =====
module lztd_seq #(
	parameter int HISTORY_BITS = lztd_pkg::HISTORY_BITS_DEF,
	parameter int MAX_RUN      = lztd_pkg::MAX_RUN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lztd_pkg::token_t in_data,
	output lztd_pkg::emit_t  emit,
	input  logic             out_free
);

	import lztd_pkg::*;

	// Comparison width holds both the distance and the produced count.
	localparam int CMP_W = (HISTORY_BITS + 1 > DIST_W) ? HISTORY_BITS + 1 : DIST_W;
	localparam int DEPTH = 1 << HISTORY_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                  state_q;
	logic [OP_W-1:0]         op_q;
	logic [BYTE_W-1:0]       lit_q;
	logic [CMP_W-1:0]        dist_q;
	logic [LEN_W-1:0]        remain_q;
	logic                    bad_q;
	logic [HISTORY_BITS-1:0] wp_q;
	logic [HISTORY_BITS:0]   prod_q;

	logic                    accept;
	logic [LEN_W-1:0]        len_sat;
	logic [CMP_W-1:0]        dist_ext;
	logic                    bad_new;
	logic [CMP_W-1:0]        src_full;
	logic                    ram_we;
	logic                    ram_re;
	logic [BYTE_W-1:0]       ram_rdata;
	logic                    fire;
	logic                    is_last;
	logic                    is_end;

	// Token intake and the distance check against bytes produced so far.
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign len_sat  = (in_data.match_length > LEN_W'(MAX_RUN)) ?
		LEN_W'(MAX_RUN) : in_data.match_length;
	assign dist_ext = CMP_W'(in_data.match_distance);
	assign bad_new  = (in_data.match_distance == '0) || (dist_ext > CMP_W'(prod_q));

	// Source of a copy lies distance bytes behind the write pointer.
	assign src_full = CMP_W'(wp_q) - dist_q;
	assign ram_re   = (state_q == S_READ);

	// Result built from the latched token and the history read data.
	assign fire    = (state_q == S_EMIT) && out_free;
	assign is_last = (remain_q == LEN_W'(1));
	assign is_end  = (op_q == OP_END);
	assign ram_we  = fire && !is_end;

	always_comb begin
		emit.valid             = (state_q == S_EMIT);
		emit.res.last_of_run   = is_last;
		emit.res.end_of_stream = is_end;
		emit.res.bad_distance  = bad_q && (op_q == OP_MATCH);
		if (op_q == OP_LITERAL) begin
			emit.res.out_byte = lit_q;
		end else if (op_q == OP_MATCH && !bad_q) begin
			emit.res.out_byte = ram_rdata;
		end else begin
			emit.res.out_byte = '0;
		end
	end

	lztd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (emit.res.out_byte),
		.re    (ram_re),
		.raddr (src_full[HISTORY_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// Sequencer: one read and one emit per copied byte of a good copy, so a write always
	// completes before the next read of the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_LITERAL;
			lit_q    <= '0;
			dist_q   <= '0;
			remain_q <= '0;
			bad_q    <= 1'b0;
			wp_q     <= '0;
			prod_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_data.operation;
						lit_q    <= in_data.literal;
						dist_q   <= dist_ext;
						remain_q <= LEN_W'(1);
						bad_q    <= 1'b0;
						case (in_data.operation)
							OP_LITERAL, OP_END: begin
								state_q <= S_EMIT;
							end
							OP_MATCH: begin
								if (len_sat != '0) begin
									remain_q <= len_sat;
									bad_q    <= bad_new;
									state_q  <= bad_new ? S_EMIT : S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (fire) begin
						if (is_end) begin
							wp_q   <= '0;
							prod_q <= '0;
						end else begin
							wp_q <= wp_q + 1'b1;
							if (!prod_q[HISTORY_BITS]) begin
								prod_q <= prod_q + 1'b1;
							end
						end
						remain_q <= remain_q - 1'b1;
						if (is_last) begin
							state_q <= S_IDLE;
						end else if (bad_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The window is never written and read in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("history written and read in the same cycle");

	// A read is always followed by the emit that consumes it.
	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_EMIT))
		else $error("read not followed by emit");

	// An end marker leaves a fresh stream behind it.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_end) |=> (wp_q == '0 && prod_q == '0))
		else $error("end of stream did not clear position");

	// A flagged copy only ever emits zero bytes.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.res.bad_distance) |-> (emit.res.out_byte == '0))
		else $error("bad distance result carries data");

	// The produced count never passes the window size.
	a_prod_sat: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q[HISTORY_BITS] |-> (prod_q[HISTORY_BITS-1:0] == '0))
		else $error("produced count exceeded window");
`endif

endmodule

// ===== bench/tb_lz77_token_decoder.sv =====
module tb_lz77_token_decoder;
	import lztd_pkg::*;

	localparam int HIST_BITS    = HISTORY_BITS_DEF;
	localparam int WINDOW_SIZE  = 1 << HIST_BITS;
	localparam int RUN_LIMIT    = MAX_RUN_DEF;
	localparam int DIST_MAX     = (1 << DIST_W) - 1;
	localparam int MAX_GAP      = 8;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_PRINTS   = 40;
	localparam int PLAN_ROWS    = 32;
	localparam int EXP_BITS     = 8;
	localparam int EXP_DEPTH    = 1 << EXP_BITS;

	// The token kind that the decoder must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// How the results of one directed row are checked.
	typedef enum logic [1:0] {
		CHECK_PREDICTED,
		CHECK_TYPED,
		CHECK_NONE
	} check_mode_t;

	typedef struct packed {
		token_t      tok;
		check_mode_t mode;
		result_t     want;
	} plan_row_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	token_t  in_data;
	logic    out_valid;
	logic    out_ready;
	result_t out_data;

	// Shadow copy of the decoder state, updated as each token transfer completes.
	logic [BYTE_W-1:0]    shadow_window [WINDOW_SIZE];
	logic [HIST_BITS-1:0] shadow_wr_pos;
	int                   shadow_fill;

	// Expected results in transfer order, kept as a ring.
	result_t             exp_ring [EXP_DEPTH];
	logic [EXP_BITS-1:0] exp_wr = '0;
	logic [EXP_BITS-1:0] exp_rd = '0;

	// Directed stimulus table.
	plan_row_t plan [PLAN_ROWS];
	int        plan_len = 0;

	int error_count = 0;
	int cycle_count = 0;

	lz77_token_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Cycle count for messages and the run timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic result_t res_of(input logic [BYTE_W-1:0] b, input logic last,
			input logic eos, input logic bad);
		result_t r;
		r.out_byte      = b;
		r.last_of_run   = last;
		r.end_of_stream = eos;
		r.bad_distance  = bad;
		return r;
	endfunction

	function automatic token_t tok_of(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] lit,
			input logic [LEN_W-1:0] len, input logic [DIST_W-1:0] distance);
		token_t t;
		t.operation      = op;
		t.literal        = lit;
		t.match_length   = len;
		t.match_distance = distance;
		return t;
	endfunction

	// Adds one row to the directed table.
	function automatic void add_row(input token_t tok, input check_mode_t mode,
			input result_t want);
		plan[plan_len].tok  = tok;
		plan[plan_len].mode = mode;
		plan[plan_len].want = want;
		plan_len++;
	endfunction

	// Appends one expected result to the ring.
	function automatic void add_expect(input result_t r);
		exp_ring[exp_wr] = r;
		exp_wr++;
	endfunction

	// Takes the oldest expected result from the ring.
	function automatic result_t take_expect();
		result_t r;
		r = exp_ring[exp_rd];
		exp_rd++;
		return r;
	endfunction

	// Every emitted byte lands in the window; the produced count saturates at its size.
	function automatic void append_history(input logic [BYTE_W-1:0] b);
		shadow_window[shadow_wr_pos] = b;
		shadow_wr_pos++;
		if (shadow_fill < WINDOW_SIZE)
			shadow_fill++;
	endfunction

	// Works out the results of one token, advances the shadow state, and
	// queues the results when asked to.
	function automatic void decode_token(input token_t tok, input bit keep);
		int                   run_len;
		logic                 bad;
		logic [HIST_BITS-1:0] src;
		logic [BYTE_W-1:0]    b;
		case (tok.operation)
		OP_LITERAL: begin
			append_history(tok.literal);
			if (keep)
				add_expect(res_of(tok.literal, 1'b1, 1'b0, 1'b0));
		end
		OP_MATCH: begin
			// Chunks longer than the run limit are cut to it; the distance is
			// judged once, before any byte of the chunk is written.
			run_len = (tok.match_length > LEN_W'(RUN_LIMIT)) ? RUN_LIMIT
				: int'(tok.match_length);
			bad = (tok.match_distance == '0) || (int'(tok.match_distance) > shadow_fill);
			for (int i = 0; i < run_len; i++) begin
				src = HIST_BITS'(shadow_wr_pos - tok.match_distance);
				b = bad ? '0 : shadow_window[src];
				append_history(b);
				if (keep)
					add_expect(res_of(b, i == run_len - 1, 1'b0, bad));
			end
		end
		OP_END: begin
			shadow_wr_pos = '0;
			shadow_fill = 0;
			if (keep)
				add_expect(res_of('0, 1'b1, 1'b1, 1'b0));
		end
		default: begin
		end
		endcase
	endfunction

	// Offers one token after a random gap, holds it until the transfer, then
	// queues what it should produce. Returns at the following falling edge.
	task automatic send_token(input token_t tok, input check_mode_t mode, input result_t typed);
		int gap;
		gap = int'($urandom_range(0, MAX_GAP));
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = tok;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		decode_token(tok, mode == CHECK_PREDICTED);
		if (mode == CHECK_TYPED)
			add_expect(typed);
		@(negedge clk);
	endtask

	// Mostly well-formed tokens: literals and matches that reach back into
	// written history, with bad distances, odd lengths, ignored kinds and
	// stream ends mixed in.
	task automatic run_random(input int count);
		token_t      t;
		int          done_items;
		int unsigned pick;
		int          reach;
		done_items = 0;
		while (done_items < count) begin
			reach = (shadow_fill > DIST_MAX) ? DIST_MAX : shadow_fill;
			pick = $urandom_range(0, 99);
			t.operation = OP_MATCH;
			t.literal = BYTE_W'($urandom_range(0, 255));
			t.match_length = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(1, 127))
				: LEN_W'($urandom_range(1, 12));
			t.match_distance = DIST_W'($urandom_range(0, DIST_MAX));
			if (pick < 30)
				t.operation = OP_LITERAL;
			else if (pick < 80 && reach != 0)
				t.match_distance = DIST_W'($urandom_range(1, reach));
			else if (pick < 84)
				t.match_distance = (reach < DIST_MAX) ? DIST_W'(reach + 1) : '0;
			else if (pick < 88)
				t.match_length = LEN_W'($urandom_range(0, 127));
			else if (pick < 94)
				t.operation = OP_UNUSED;
			else
				t.operation = OP_END;
			if (t.operation != OP_UNUSED && !(t.operation == OP_MATCH && t.match_length == 0))
				done_items++;
			send_token(t, CHECK_PREDICTED, '0);
		end
	endtask

	// Result side: random stalls, then each transfer is checked against the
	// oldest pending expectation.
	initial begin : result_checker
		result_t want;
		int      stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = int'($urandom_range(0, MAX_GAP));
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (exp_wr == exp_rd) begin
				report_mismatch($sformatf("unexpected result %p", out_data));
			end else begin
				want = take_expect();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						out_data.out_byte, want.out_byte));
				if (out_data.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						out_data.last_of_run, want.last_of_run));
				if (out_data.end_of_stream !== want.end_of_stream)
					report_mismatch($sformatf("end_of_stream %b, expected %b",
						out_data.end_of_stream, want.end_of_stream));
				if (out_data.bad_distance !== want.bad_distance)
					report_mismatch($sformatf("bad_distance %b, expected %b",
						out_data.bad_distance, want.bad_distance));
			end
		end
	end

	// Token side: reset, directed table, random traffic, then drain.
	initial begin : token_source
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		shadow_wr_pos = '0;
		shadow_fill = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// A fresh stream has no history: any distance is out of range, and a
		// zero-length chunk or an unused kind gives nothing.
		add_row(tok_of(OP_MATCH, 8'h00, 7'd1, 16'd1), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b0, 1'b1));
		add_row(tok_of(OP_MATCH, 8'h00, 7'd0, 16'd1), CHECK_NONE, '0);
		add_row(tok_of(OP_UNUSED, 8'hFF, 7'h7F, 16'hFFFF), CHECK_NONE, '0);
		// Literal extremes.
		add_row(tok_of(OP_LITERAL, 8'hFF, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'hFF, 1'b1, 1'b0, 1'b0));
		add_row(tok_of(OP_LITERAL, 8'h00, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b0, 1'b0));
		add_row(tok_of(OP_LITERAL, 8'hA5, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'hA5, 1'b1, 1'b0, 1'b0));
		// Overlapping copies, zero distance, and chunks past the run limit.
		add_row(tok_of(OP_MATCH, 8'h00, 7'd4, 16'd1), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'h3C, 7'd3, 16'd3), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'h00, 7'd2, 16'd0), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'h00, 7'd1, 16'd0), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b0, 1'b1));
		add_row(tok_of(OP_MATCH, 8'h00, 7'd127, 16'd2), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'hFF, 7'd64, 16'd5), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'h00, 7'd65, 16'd1), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_MATCH, 8'h00, 7'd1, 16'hFFFF), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b0, 1'b1));
		// End markers, the second one on an empty stream.
		add_row(tok_of(OP_END, 8'h00, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b1, 1'b0));
		add_row(tok_of(OP_END, 8'hFF, 7'h7F, 16'hFFFF), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b1, 1'b0));
		// Distance exactly at, then just past, the bytes produced so far.
		add_row(tok_of(OP_LITERAL, 8'h5A, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'h5A, 1'b1, 1'b0, 1'b0));
		add_row(tok_of(OP_LITERAL, 8'hC3, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'hC3, 1'b1, 1'b0, 1'b0));
		add_row(tok_of(OP_MATCH, 8'h00, 7'd1, 16'd2), CHECK_TYPED,
			res_of(8'h5A, 1'b1, 1'b0, 1'b0));
		add_row(tok_of(OP_MATCH, 8'h00, 7'd1, 16'd4), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b0, 1'b1));
		add_row(tok_of(OP_MATCH, 8'h00, 7'd3, 16'd4), CHECK_PREDICTED, '0);
		add_row(tok_of(OP_END, 8'h00, 7'd0, 16'd0), CHECK_TYPED,
			res_of(8'h00, 1'b1, 1'b1, 1'b0));

		for (int i = 0; i < plan_len; i++)
			send_token(plan[i].tok, plan[i].mode, plan[i].want);

		run_random(120);

		// Drain, then give a stray extra result time to show up.
		in_valid = 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
